// ----- design/qofh_pkg.sv -----
// ----------------------------------------------------------------------------
// qofh_pkg
// Types, widths and helpers shared by the obstacle first-hit block.
// ----------------------------------------------------------------------------
package qofh_pkg;

  localparam int CoordBits    = 16;
  localparam int MaxObstacles = 256;
  localparam int IdxBits      = $clog2(MaxObstacles);
  localparam int IndexOutBits = 8;
  localparam int CfgIdxBits   = 4;
  localparam int DiffBits     = CoordBits + 1;
  localparam int ProdBits     = 2 * DiffBits;
  localparam int CrossBits    = ProdBits + 1;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffBits-1:0]  diff_t;
  typedef logic signed [ProdBits-1:0]  prod_t;
  typedef logic signed [CrossBits-1:0] cross_t;
  typedef logic [IdxBits-1:0]          scan_idx_t;
  typedef logic [IndexOutBits-1:0]     index_out_t;
  typedef logic [CfgIdxBits-1:0]       cfg_idx_t;

  localparam scan_idx_t LastScanIdx = scan_idx_t'(MaxObstacles - 1);

  typedef enum logic [CfgIdxBits-1:0] {
    REG_BOX_X0 = 4'd0,
    REG_BOX_Y0 = 4'd1,
    REG_BOX_X1 = 4'd2,
    REG_BOX_Y1 = 4'd3,
    REG_BOX_X2 = 4'd4,
    REG_BOX_Y2 = 4'd5,
    REG_BOX_X3 = 4'd6,
    REG_BOX_Y3 = 4'd7
  } reg_idx_e;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    coord_t [3:0] x;
    coord_t [3:0] y;
  } quad_t;

  typedef struct packed {
    point_t center;
    quad_t  corners;
    logic   last_obstacle;
  } obst_item_t;

  // Exact difference of two coordinates, one bit wider than the inputs.
  function automatic diff_t coord_diff(coord_t a, coord_t b);
    diff_t ea;
    diff_t eb;
    ea = {a[CoordBits-1], a};
    eb = {b[CoordBits-1], b};
    return ea - eb;
  endfunction

  function automatic index_out_t index_out(scan_idx_t idx);
    logic [IdxBits+IndexOutBits-1:0] ext;
    ext = {{IndexOutBits{1'b0}}, idx};
    return ext[IndexOutBits-1:0];
  endfunction

endpackage

// ----- design/qofh_cfg_if.sv -----
// ----------------------------------------------------------------------------
// qofh_cfg_if
// Register write channel: index and data with valid/ready.
// ----------------------------------------------------------------------------
interface qofh_cfg_if;
  logic                     valid;
  logic                     ready;
  qofh_pkg::cfg_idx_t       index;
  logic [qofh_pkg::CoordBits-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/qofh_in_if.sv -----
// ----------------------------------------------------------------------------
// qofh_in_if
// Obstacle request channel: center, four corners and end-of-scan mark.
// ----------------------------------------------------------------------------
interface qofh_in_if;
  logic             valid;
  logic             ready;
  qofh_pkg::coord_t center_x;
  qofh_pkg::coord_t center_y;
  qofh_pkg::coord_t obst_x0;
  qofh_pkg::coord_t obst_y0;
  qofh_pkg::coord_t obst_x1;
  qofh_pkg::coord_t obst_y1;
  qofh_pkg::coord_t obst_x2;
  qofh_pkg::coord_t obst_y2;
  qofh_pkg::coord_t obst_x3;
  qofh_pkg::coord_t obst_y3;
  logic             last_obstacle;

  modport source (
    output valid, output center_x, output center_y,
    output obst_x0, output obst_y0, output obst_x1, output obst_y1,
    output obst_x2, output obst_y2, output obst_x3, output obst_y3,
    output last_obstacle, input ready
  );
  modport sink (
    input valid, input center_x, input center_y,
    input obst_x0, input obst_y0, input obst_x1, input obst_y1,
    input obst_x2, input obst_y2, input obst_x3, input obst_y3,
    input last_obstacle, output ready
  );
endinterface

// ----- design/qofh_out_if.sv -----
// ----------------------------------------------------------------------------
// qofh_out_if
// Result channel: per-obstacle hit flag and running first-hit summary.
// ----------------------------------------------------------------------------
interface qofh_out_if;
  logic                 valid;
  logic                 ready;
  logic                 in_box;
  logic                 found;
  qofh_pkg::index_out_t first_index;
  logic                 scan_end;

  modport source (
    output valid, output in_box, output found, output first_index,
    output scan_end, input ready
  );
  modport sink (
    input valid, input in_box, input found, input first_index,
    input scan_end, output ready
  );
endinterface

// ----- design/qofh_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// qofh_cfg_regs
// Holds the four world-space corners of the search box.
// ----------------------------------------------------------------------------
module qofh_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  qofh_cfg_if.sink        cfg_i,
  output qofh_pkg::quad_t box_o
);
  import qofh_pkg::*;

  quad_t box_q;
  logic  wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid && cfg_i.ready;
  assign box_o       = box_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= '0;
    end else if (wr_en) begin
      case (reg_idx_e'(cfg_i.index))
        REG_BOX_X0: box_q.x[0] <= cfg_i.data;
        REG_BOX_Y0: box_q.y[0] <= cfg_i.data;
        REG_BOX_X1: box_q.x[1] <= cfg_i.data;
        REG_BOX_Y1: box_q.y[1] <= cfg_i.data;
        REG_BOX_X2: box_q.x[2] <= cfg_i.data;
        REG_BOX_Y2: box_q.y[2] <= cfg_i.data;
        REG_BOX_X3: box_q.x[3] <= cfg_i.data;
        REG_BOX_Y3: box_q.y[3] <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

// ----- design/qofh_point_test.sv -----
// ----------------------------------------------------------------------------
// qofh_point_test
// Tests one point against one quadrangle with four exact cross products.
// ----------------------------------------------------------------------------
module qofh_point_test (
  input  qofh_pkg::point_t pt_i,
  input  qofh_pkg::quad_t  quad_i,
  output logic             inside_o
);
  import qofh_pkg::*;

  logic [3:0] side_ok;

  for (genvar s = 0; s < 4; s++) begin : g_side
    localparam int N = (s + 1) % 4;
    diff_t  ex, ey, dx, dy;
    prod_t  p_a, p_b;
    cross_t cr;

    assign ex  = coord_diff(quad_i.x[N], quad_i.x[s]);
    assign ey  = coord_diff(quad_i.y[N], quad_i.y[s]);
    assign dx  = coord_diff(pt_i.x, quad_i.x[s]);
    assign dy  = coord_diff(pt_i.y, quad_i.y[s]);
    assign p_a = ex * dy;
    assign p_b = ey * dx;
    // Full-width difference; a point on the side line has a zero result.
    assign cr  = {p_a[ProdBits-1], p_a} - {p_b[ProdBits-1], p_b};
    assign side_ok[s] = !cr[CrossBits-1];
  end

  assign inside_o = &side_ok;

endmodule

// ----- design/qofh_overlap.sv -----
// ----------------------------------------------------------------------------
// qofh_overlap
// Decides whether one obstacle touches the search box (9 point tests).
// ----------------------------------------------------------------------------
module qofh_overlap (
  input  qofh_pkg::quad_t      box_i,
  input  qofh_pkg::obst_item_t item_i,
  output logic                 hit_o
);
  import qofh_pkg::*;

  logic       center_in;
  logic [3:0] obst_in_box;
  logic [3:0] box_in_obst;

  qofh_point_test u_center (
    .pt_i     (item_i.center),
    .quad_i   (box_i),
    .inside_o (center_in)
  );

  for (genvar k = 0; k < 4; k++) begin : g_corner
    point_t obst_pt;
    point_t box_pt;

    assign obst_pt.x = item_i.corners.x[k];
    assign obst_pt.y = item_i.corners.y[k];
    assign box_pt.x  = box_i.x[k];
    assign box_pt.y  = box_i.y[k];

    qofh_point_test u_obst_pt (
      .pt_i     (obst_pt),
      .quad_i   (box_i),
      .inside_o (obst_in_box[k])
    );

    qofh_point_test u_box_pt (
      .pt_i     (box_pt),
      .quad_i   (item_i.corners),
      .inside_o (box_in_obst[k])
    );
  end

  assign hit_o = center_in || (|obst_in_box) || (|box_in_obst);

endmodule

// ----- design/quadrangle_obstacle_first_hit.sv -----
// ----------------------------------------------------------------------------
// quadrangle_obstacle_first_hit
// Streams obstacles against a configured search box and tracks the first hit.
//
//   Channel   Dir   Carries                                   Handshake
//   cfg_i     in    register index, box corner coordinate     valid/ready
//   obst_i    in    obstacle center, corners, last_obstacle   valid/ready
//   res_o     out   in_box, found, first_index, scan_end      valid/ready
//
// One obstacle is accepted per cycle while res_o does not stall; it is held in the
// request register, then its result in the result register, before it leaves.
// The rate is set by the request register feeding 36 parallel cross products
// and the result register behind them. The configuration port is always ready.
// Reset clears the box corners and the scan state. A stalled result holds and
// the request register takes one more request behind it; then the input stalls.
// ----------------------------------------------------------------------------
module quadrangle_obstacle_first_hit (
  input  logic       clk_i,
  input  logic       rst_ni,
  qofh_cfg_if.sink   cfg_i,
  qofh_in_if.sink    obst_i,
  qofh_out_if.source res_o
);
  import qofh_pkg::*;

  quad_t      box;
  obst_item_t in_item;
  obst_item_t s1_item_q;
  logic       s1_valid_q;
  logic       res_valid_q;
  logic       res_in_box_q;
  logic       res_found_q;
  index_out_t res_index_q;
  logic       res_end_q;
  logic       in_fire;
  logic       s2_load;
  logic       hit;

  scan_idx_t  scan_pos_q, scan_pos_d;
  logic       hit_seen_q, hit_seen_d;
  scan_idx_t  hit_pos_q, hit_pos_d;
  logic       found;
  scan_idx_t  first_pos;

  qofh_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .box_o  (box)
  );

  assign in_item.center.x        = obst_i.center_x;
  assign in_item.center.y        = obst_i.center_y;
  assign in_item.corners.x[0]    = obst_i.obst_x0;
  assign in_item.corners.y[0]    = obst_i.obst_y0;
  assign in_item.corners.x[1]    = obst_i.obst_x1;
  assign in_item.corners.y[1]    = obst_i.obst_y1;
  assign in_item.corners.x[2]    = obst_i.obst_x2;
  assign in_item.corners.y[2]    = obst_i.obst_y2;
  assign in_item.corners.x[3]    = obst_i.obst_x3;
  assign in_item.corners.y[3]    = obst_i.obst_y3;
  assign in_item.last_obstacle   = obst_i.last_obstacle;

  // The request register moves on whenever the result register is free or drains.
  assign s2_load      = s1_valid_q && (!res_valid_q || res_o.ready);
  assign obst_i.ready = !s1_valid_q || s2_load;
  assign in_fire      = obst_i.valid && obst_i.ready;

  qofh_overlap u_overlap (
    .box_i  (box),
    .item_i (s1_item_q),
    .hit_o  (hit)
  );

  assign found     = hit_seen_q || hit;
  assign first_pos = hit_seen_q ? hit_pos_q : scan_pos_q;

  always_comb begin
    scan_pos_d = scan_pos_q;
    hit_seen_d = hit_seen_q;
    hit_pos_d  = hit_pos_q;
    if (s2_load) begin
      if (s1_item_q.last_obstacle) begin
        scan_pos_d = '0;
        hit_seen_d = 1'b0;
        hit_pos_d  = '0;
      end else begin
        hit_seen_d = found;
        hit_pos_d  = first_pos;
        if (scan_pos_q != LastScanIdx) begin
          scan_pos_d = scan_pos_q + scan_idx_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      scan_pos_q  <= '0;
      hit_seen_q  <= 1'b0;
      hit_pos_q   <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s2_load) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_load) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      scan_pos_q <= scan_pos_d;
      hit_seen_q <= hit_seen_d;
      hit_pos_q  <= hit_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_item;
    end
    if (s2_load) begin
      res_in_box_q <= hit;
      res_found_q  <= found;
      res_index_q  <= found ? index_out(first_pos) : '0;
      res_end_q    <= s1_item_q.last_obstacle;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.in_box      = res_in_box_q;
  assign res_o.found       = res_found_q;
  assign res_o.first_index = res_index_q;
  assign res_o.scan_end    = res_end_q;

  a_hit_implies_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.in_box |-> res_o.found)
    else $error("result reports a hit without found");

  a_no_hit_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.found |-> res_o.first_index == '0)
    else $error("first_index nonzero while nothing found");

  a_scan_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load && s1_item_q.last_obstacle |=> (scan_pos_q == '0) && !hit_seen_q)
    else $error("scan state not cleared after last obstacle");

  a_scan_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s2_load |=> $stable(scan_pos_q) && $stable(hit_seen_q))
    else $error("scan state moved without a result");

endmodule

// ----- verif/tb_quadrangle_obstacle_first_hit.sv -----
// ----------------------------------------------------------------------------
// tb_quadrangle_obstacle_first_hit
// Streams obstacles through the first-hit block and checks every result.
// A directed table covers the reset box, field extremes, boundary touches,
// winding order, degenerate shapes and ignored register writes. Random
// phases follow, each with its own search box, including one scan that runs
// past the saturating scan index. Typed rows carry their expected results;
// the rest use the bench's exact cross-product model; both channels stall at random.
// ----------------------------------------------------------------------------
module tb_quadrangle_obstacle_first_hit;
  timeunit 1ns;
  timeprecision 1ps;

  import qofh_pkg::*;

  localparam int WatchdogLimit  = 3000;
  localparam int NumPhases      = 11;
  localparam int LongScanPhase  = 3;
  localparam int ItemsPerPhase  = 110;
  localparam int LongScanItems  = 300;
  localparam int LongScanMisses = 270;
  localparam int FirstUnusedIdx = int'(REG_BOX_Y3) + 1;
  localparam int LastCfgIdx     = (1 << CfgIdxBits) - 1;

  localparam reg_idx_e XRegs[4] = '{REG_BOX_X0, REG_BOX_X1, REG_BOX_X2, REG_BOX_X3};
  localparam reg_idx_e YRegs[4] = '{REG_BOX_Y0, REG_BOX_Y1, REG_BOX_Y2, REG_BOX_Y3};

  typedef enum logic [1:0] {
    BOX_RESET,
    BOX_SQUARE,
    BOX_FULL_RANGE,
    BOX_CLOCKWISE
  } box_preset_e;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
    quad_t  q;
    logic   last;
  } obstacle_t;

  typedef struct packed {
    logic       in_box;
    logic       found;
    index_out_t first_index;
    logic       scan_end;
  } hit_report_t;

  typedef struct packed {
    box_preset_e box;
    obstacle_t   obst;
    logic        typed;
    hit_report_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  qofh_cfg_if cfg_if ();
  qofh_in_if  obst_if ();
  qofh_out_if res_if ();

  quadrangle_obstacle_first_hit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .obst_i (obst_if),
    .res_o  (res_if)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Model state: box corners and scan tracking.
  quad_t       box_q     = '0;
  int          scan_pos  = 0;
  logic        hit_seen  = 1'b0;
  int          hit_pos   = 0;

  hit_report_t pending_reports[$];
  dir_row_t    dir_rows[$];
  int          mismatches = 0;
  int          idle_cycles = 0;

  logic        row_typed = 1'b0;
  hit_report_t row_report = '0;
  logic        tx_busy = 1'b1;
  logic        rx_busy = 1'b1;
  int          tx_count = 0;

  function automatic logic point_in_quad(coord_t px, coord_t py, quad_t q);
    longint ex;
    longint ey;
    longint dx;
    longint dy;
    int     j;
    for (int i = 0; i < 4; i++) begin
      j  = (i + 1) % 4;
      ex = longint'($signed(q.x[j])) - longint'($signed(q.x[i]));
      ey = longint'($signed(q.y[j])) - longint'($signed(q.y[i]));
      dx = longint'($signed(px)) - longint'($signed(q.x[i]));
      dy = longint'($signed(py)) - longint'($signed(q.y[i]));
      if (ex * dy - ey * dx < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic hit_report_t score_obstacle(obstacle_t o);
    hit_report_t r;
    logic        hit;
    hit = point_in_quad(o.cx, o.cy, box_q);
    for (int i = 0; i < 4 && !hit; i++) begin
      hit = point_in_quad(o.q.x[i], o.q.y[i], box_q) ||
            point_in_quad(box_q.x[i], box_q.y[i], o.q);
    end
    if (hit && !hit_seen) begin
      hit_seen = 1'b1;
      hit_pos  = scan_pos;
    end
    r.in_box      = hit;
    r.found       = hit_seen;
    r.first_index = hit_seen ? index_out_t'(hit_pos) : '0;
    r.scan_end    = o.last;
    if (o.last) begin
      scan_pos = 0;
      hit_seen = 1'b0;
      hit_pos  = 0;
    end else if (scan_pos < MaxObstacles - 1) begin
      scan_pos++;
    end
    return r;
  endfunction

  function automatic coord_t clamp_coord(int v);
    if (v > 32767) return coord_t'(32767);
    if (v < -32768) return coord_t'(-32768);
    return coord_t'(v);
  endfunction

  function automatic int rand_signed(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic quad_t mk_quad(int x0, int y0, int x1, int y1,
                                    int x2, int y2, int x3, int y3);
    quad_t q;
    q.x[0] = coord_t'(x0);
    q.y[0] = coord_t'(y0);
    q.x[1] = coord_t'(x1);
    q.y[1] = coord_t'(y1);
    q.x[2] = coord_t'(x2);
    q.y[2] = coord_t'(y2);
    q.x[3] = coord_t'(x3);
    q.y[3] = coord_t'(y3);
    return q;
  endfunction

  function automatic hit_report_t mk_report(logic in_box, logic found, int idx, logic scan_end);
    hit_report_t r;
    r.in_box      = in_box;
    r.found       = found;
    r.first_index = index_out_t'(idx);
    r.scan_end    = scan_end;
    return r;
  endfunction

  // Parallelogram around (cx, cy) with edge vectors up to sz, wound as asked.
  function automatic quad_t mk_parallelogram(int cx, int cy, int sz, logic ccw);
    quad_t q;
    int    ux, uy, vx, vy, t, px, py;
    ux = rand_signed(sz);
    uy = rand_signed(sz);
    vx = rand_signed(sz);
    vy = rand_signed(sz);
    if ((ccw && (ux * vy - uy * vx < 0)) || (!ccw && (ux * vy - uy * vx > 0))) begin
      t = ux; ux = vx; vx = t;
      t = uy; uy = vy; vy = t;
    end
    px = cx - (ux + vx) / 2;
    py = cy - (uy + vy) / 2;
    q.x[0] = clamp_coord(px);
    q.y[0] = clamp_coord(py);
    q.x[1] = clamp_coord(px + ux);
    q.y[1] = clamp_coord(py + uy);
    q.x[2] = clamp_coord(px + ux + vx);
    q.y[2] = clamp_coord(py + uy + vy);
    q.x[3] = clamp_coord(px + vx);
    q.y[3] = clamp_coord(py + vy);
    return q;
  endfunction

  function automatic quad_t preset_box(box_preset_e sel);
    case (sel)
      BOX_SQUARE:     return mk_quad(-1024, -1024, 1024, -1024, 1024, 1024, -1024, 1024);
      BOX_FULL_RANGE: return mk_quad(-32768, -32768, 32767, -32768,
                                     32767, 32767, -32768, 32767);
      BOX_CLOCKWISE:  return mk_quad(-1024, -1024, -1024, 1024, 1024, 1024, 1024, -1024);
      default:        return '0;
    endcase
  endfunction

  function automatic quad_t random_box();
    quad_t q;
    int    kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0: q = mk_quad($urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
      1: q = mk_parallelogram(rand_signed(12000), rand_signed(12000), 10000, 1'b0);
      2: begin
        q.x = {4{clamp_coord(rand_signed(12000))}};
        q.y = {4{clamp_coord(rand_signed(12000))}};
      end
      default: q = mk_parallelogram(rand_signed(12000), rand_signed(12000), 10000, 1'b1);
    endcase
    return q;
  endfunction

  // Obstacle placed around the current box so that hits and misses both occur.
  function automatic obstacle_t random_obstacle(logic last);
    obstacle_t    o;
    logic [191:0] raw;
    int           kind, mx, my, spread, sz, cx, cy;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      o   = raw[$bits(obstacle_t)-1:0];
    end else begin
      mx = 0;
      my = 0;
      for (int i = 0; i < 4; i++) begin
        mx += int'($signed(box_q.x[i]));
        my += int'($signed(box_q.y[i]));
      end
      case ($urandom_range(0, 2))
        0:       spread = 1500;
        1:       spread = 6000;
        default: spread = 24000;
      endcase
      case ($urandom_range(0, 2))
        0:       sz = 300;
        1:       sz = 2500;
        default: sz = 9000;
      endcase
      cx   = mx / 4 + rand_signed(spread);
      cy   = my / 4 + rand_signed(spread);
      o.cx = clamp_coord(cx);
      o.cy = clamp_coord(cy);
      if (kind == 1) begin
        o.q.x = {4{o.cx}};
        o.q.y = {4{o.cy}};
      end else begin
        o.q = mk_parallelogram(cx, cy, sz, kind > 4);
      end
    end
    o.last = last;
    return o;
  endfunction

  task automatic add_row(box_preset_e box, int cx, int cy, quad_t q, logic last,
                         logic typed, hit_report_t want);
    dir_row_t r;
    r.box       = box;
    r.obst.cx   = coord_t'(cx);
    r.obst.cy   = coord_t'(cy);
    r.obst.q    = q;
    r.obst.last = last;
    r.typed     = typed;
    r.want      = want;
    dir_rows.push_back(r);
  endtask

  task automatic cfg_write(cfg_idx_t idx, coord_t value);
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk);
  endtask

  task automatic program_box(quad_t q);
    cfg_write(cfg_idx_t'($urandom_range(FirstUnusedIdx, LastCfgIdx)), coord_t'($urandom));
    for (int i = 0; i < 4; i++) begin
      cfg_write(XRegs[i], q.x[i]);
      cfg_write(YRegs[i], q.y[i]);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_obstacle(obstacle_t o, logic typed, hit_report_t want);
    int gap;
    if (tx_count % 25 == 0) tx_busy = ($urandom_range(0, 2) != 0);
    tx_count++;
    gap = tx_busy ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      obst_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    obst_if.center_x      <= o.cx;
    obst_if.center_y      <= o.cy;
    obst_if.obst_x0       <= o.q.x[0];
    obst_if.obst_y0       <= o.q.y[0];
    obst_if.obst_x1       <= o.q.x[1];
    obst_if.obst_y1       <= o.q.y[1];
    obst_if.obst_x2       <= o.q.x[2];
    obst_if.obst_y2       <= o.q.y[2];
    obst_if.obst_x3       <= o.q.x[3];
    obst_if.obst_y3       <= o.q.y[3];
    obst_if.last_obstacle <= o.last;
    obst_if.valid         <= 1'b1;
    row_typed             <= typed;
    row_report            <= want;
    do @(posedge clk); while (!(obst_if.valid && obst_if.ready));
    @(negedge clk);
  endtask

  // Holds the obstacle requests back until every outstanding result is back.
  task automatic wait_drained();
    obst_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic note_field(string field, int want, int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    end
  endtask

  task automatic build_directed();
    hit_report_t none;
    none = '0;
    // With the box at reset all four corners coincide, so every point is inside.
    add_row(BOX_RESET, -32768, -32768, mk_quad(-32768, -32768, -32768, -32768,
            -32768, -32768, -32768, -32768), 1'b0, 1'b1, mk_report(1, 1, 0, 0));
    add_row(BOX_RESET, 32767, 32767, mk_quad(32767, 32767, 32767, 32767,
            32767, 32767, 32767, 32767), 1'b0, 1'b1, mk_report(1, 1, 0, 0));
    add_row(BOX_RESET, 21845, -21846, mk_quad(21845, -21846, -21846, 21845,
            21845, -21846, -21846, 21845), 1'b1, 1'b1, mk_report(1, 1, 0, 1));
    add_row(BOX_SQUARE, 10000, 10000, mk_quad(9900, 9900, 10100, 9900,
            10100, 10100, 9900, 10100), 1'b0, 1'b0, none);
    add_row(BOX_SQUARE, 5000, 5000, mk_quad(-4000, -4000, -4000, 4000,
            4000, 4000, 4000, -4000), 1'b0, 1'b0, none);
    add_row(BOX_SQUARE, 5000, 5000, mk_quad(5000, 5000, 5000, 5000,
            5000, 5000, 5000, 5000), 1'b0, 1'b0, none);
    add_row(BOX_SQUARE, 1024, 0, mk_quad(2900, -100, 3100, -100,
            3100, 100, 2900, 100), 1'b0, 1'b0, none);
    add_row(BOX_SQUARE, 20000, 20000, mk_quad(512, 512, 30000, 20000,
            30000, 30000, 20000, 30000), 1'b0, 1'b0, none);
    add_row(BOX_SQUARE, -20000, 0, mk_quad(-30000, -30000, 30000, -30000,
            30000, 30000, -30000, 30000), 1'b1, 1'b0, none);
    add_row(BOX_SQUARE, 3000, 3000, mk_quad(1024, 1024, 5000, 1024,
            5000, 5000, 1024, 5000), 1'b0, 1'b0, none);
    add_row(BOX_SQUARE, -5000, 3000, mk_quad(-5000, 0, 5000, 0,
            5000, 0, -5000, 0), 1'b1, 1'b0, none);
    // The full-range box contains every representable point, edges included.
    add_row(BOX_FULL_RANGE, -32768, -32768, mk_quad(-32768, -32768, -32768, -32768,
            -32768, -32768, -32768, -32768), 1'b0, 1'b1, mk_report(1, 1, 0, 0));
    add_row(BOX_FULL_RANGE, 32767, 32767, mk_quad(32767, 32767, 32767, 32767,
            32767, 32767, 32767, 32767), 1'b1, 1'b1, mk_report(1, 1, 0, 1));
    add_row(BOX_FULL_RANGE, 32767, -32768, mk_quad(-32768, 32767, 32767, -32768,
            -32768, 32767, 32767, -32768), 1'b1, 1'b1, mk_report(1, 1, 0, 1));
    add_row(BOX_CLOCKWISE, 0, 0, mk_quad(-100, -100, 100, -100,
            100, 100, -100, 100), 1'b0, 1'b0, none);
    add_row(BOX_CLOCKWISE, 20000, 0, mk_quad(-30000, -30000, 30000, -30000,
            30000, 30000, -30000, 30000), 1'b1, 1'b0, none);
    add_row(BOX_CLOCKWISE, 0, 0, mk_quad(-30000, -30000, -30000, 30000,
            30000, 30000, 30000, -30000), 1'b1, 1'b0, none);
  endtask

  // Result sink with random stalls, switching between busy and quiet stretches.
  initial begin : result_sink
    int stall;
    int taken;
    res_if.ready = 1'b0;
    taken = 0;
    forever begin
      if (taken % 30 == 0) rx_busy = ($urandom_range(0, 2) != 0);
      stall = rx_busy ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!(res_if.valid && res_if.ready));
      taken++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : monitor
    obstacle_t   seen;
    hit_report_t want;
    if (cfg_if.valid && cfg_if.ready) begin
      if (cfg_if.index <= REG_BOX_Y3) begin
        if (cfg_if.index[0]) box_q.y[cfg_if.index[2:1]] = cfg_if.data;
        else box_q.x[cfg_if.index[2:1]] = cfg_if.data;
      end
    end
    if (obst_if.valid && obst_if.ready) begin
      seen.cx   = obst_if.center_x;
      seen.cy   = obst_if.center_y;
      seen.q    = mk_quad(obst_if.obst_x0, obst_if.obst_y0, obst_if.obst_x1,
                          obst_if.obst_y1, obst_if.obst_x2, obst_if.obst_y2,
                          obst_if.obst_x3, obst_if.obst_y3);
      seen.last = obst_if.last_obstacle;
      want      = score_obstacle(seen);
      pending_reports.push_back(row_typed ? row_report : want);
    end
    if (res_if.valid && res_if.ready) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result arrived with no request outstanding");
      end else begin
        want = pending_reports.pop_front();
        note_field("in_box", want.in_box, res_if.in_box);
        note_field("found", want.found, res_if.found);
        note_field("first_index", want.first_index, res_if.first_index);
        note_field("scan_end", want.scan_end, res_if.scan_end);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((cfg_if.valid && cfg_if.ready) || (obst_if.valid && obst_if.ready) ||
        (res_if.valid && res_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    box_preset_e cur_box;
    int          left;
    logic        last;
    obstacle_t   o;

    rst_n                 = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = '0;
    cfg_if.data           = '0;
    obst_if.valid         = 1'b0;
    obst_if.center_x      = '0;
    obst_if.center_y      = '0;
    obst_if.obst_x0       = '0;
    obst_if.obst_y0       = '0;
    obst_if.obst_x1       = '0;
    obst_if.obst_y1       = '0;
    obst_if.obst_x2       = '0;
    obst_if.obst_y2       = '0;
    obst_if.obst_x3       = '0;
    obst_if.obst_y3       = '0;
    obst_if.last_obstacle = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    build_directed();
    cur_box = BOX_RESET;
    foreach (dir_rows[r]) begin
      if (dir_rows[r].box != cur_box) begin
        wait_drained();
        cur_box = dir_rows[r].box;
        program_box(preset_box(cur_box));
      end
      send_obstacle(dir_rows[r].obst, dir_rows[r].typed, dir_rows[r].want);
    end

    left = 0;
    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      if (ph == LongScanPhase) begin
        // One scan longer than the index range; the first hit lands past saturation.
        program_box(preset_box(BOX_SQUARE));
        for (int n = 0; n < LongScanItems; n++) begin
          last = (n == LongScanItems - 1);
          if (n < LongScanMisses) begin
            o.cx   = clamp_coord(20000 + $urandom_range(0, 1000));
            o.cy   = clamp_coord(-20000);
            o.q    = mk_parallelogram(int'($signed(o.cx)), -20000, 300, 1'b1);
            o.last = last;
          end else begin
            o = random_obstacle(last);
          end
          send_obstacle(o, 1'b0, '0);
        end
        left = 0;
      end else begin
        program_box(random_box());
        for (int n = 0; n < ItemsPerPhase; n++) begin
          if (left == 0)
            left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 12);
          last = (left == 1);
          left--;
          send_obstacle(random_obstacle(last), 1'b0, '0);
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/qofh_pkg.sv
design/qofh_cfg_if.sv
design/qofh_in_if.sv
design/qofh_out_if.sv
design/qofh_cfg_regs.sv
design/qofh_point_test.sv
design/qofh_overlap.sv
design/quadrangle_obstacle_first_hit.sv
verif/tb_quadrangle_obstacle_first_hit.sv
